// ----- design/ppm_frame_decoder_assert.svh -----
// Assertion macros shared by the PPM frame decoder RTL.
// Expects a clock named clk and a synchronous reset named rst in the including module.
`ifndef PPM_FRAME_DECODER_ASSERT_SVH
`define PPM_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTH
// The condition implies the property in the same cycle.
`define PPMFD_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ppm_frame_decoder: same-cycle assertion failed");
// The condition implies the property in the next cycle.
`define PPMFD_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ppm_frame_decoder: next-cycle assertion failed");
`else
`define PPMFD_ASSERT_IMP(lbl, cond, prop)
`define PPMFD_ASSERT_NXT(lbl, cond, prop)
`endif
`endif

// ----- design/ppmfd_pkg.sv -----
// Package for the PPM frame decoder: constants, sequencer states and shared-unit types.
// No dependencies.
`timescale 1ns / 1ps

package ppmfd_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int WIDTH_W          = 16;
  localparam int SILENCE_W        = 20;
  localparam int CFG_INDEX_W      = 8;
  localparam int CFG_DATA_W       = 32;
  localparam int CHANNEL_W        = 3;

  localparam logic [WIDTH_W-1:0]   SYNC_RESET     = 16'd3000;
  localparam logic [SILENCE_W-1:0] FAILSAFE_RESET = 20'd100000;
  localparam logic [WIDTH_W-1:0]   WIDTH_MAX      = 16'hFFFF;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX    = 20'hFFFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE       = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SYNC,
    ST_SILENCE,
    ST_FAILCHK,
    ST_FAIL,
    ST_RD,
    ST_PUB
  } state_t;

  typedef enum logic {
    ALU_INC,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [SILENCE_W-1:0] a;
    logic [SILENCE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SILENCE_W-1:0] result;
    logic                 gt;
  } alu_rsp_t;

endpackage

// ----- design/ppmfd_alu.sv -----
// Shared arithmetic unit of the PPM frame decoder: saturating increment and compare.
// Depends on ppmfd_pkg.
`timescale 1ns / 1ps

module ppmfd_alu (
  input  ppmfd_pkg::alu_req_t req,
  output ppmfd_pkg::alu_rsp_t rsp
);

  // For an increment, b carries the saturation limit.
  always_comb begin
    rsp.gt = (req.a > req.b);
    case (req.op)
      ppmfd_pkg::ALU_INC: begin
        rsp.result = (req.a == req.b) ? req.a : req.a + 1'b1;
      end
      ppmfd_pkg::ALU_GT: begin
        rsp.result = req.a;
      end
      default: begin
        rsp.result = req.a;
      end
    endcase
  end

endmodule

// ----- design/ppmfd_store.sv -----
// Channel width store of the PPM frame decoder: one write port, one registered read port.
// Depends on ppmfd_pkg.
`timescale 1ns / 1ps

module ppmfd_store #(
  parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] wr_addr,
  input  logic [ppmfd_pkg::WIDTH_W-1:0]          wr_data,
  input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
  output logic [ppmfd_pkg::WIDTH_W-1:0]          rd_data
);

  logic [ppmfd_pkg::WIDTH_W-1:0] mem [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/ppm_frame_decoder.sv -----
// PPM frame decoder top level: sequencer around one shared increment/compare unit.
// An edge item steps IDLE, COUNT, SYNC; an item without an edge IDLE, COUNT, SILENCE, FAILCHK.
// A published frame adds RD and PUB per channel, a failsafe result FAIL, plus output stalls.
// One item at a time; the sequencer and its single shared unit set the rate.
// Synchronous active-high reset clears control state and loads the register defaults.
// Depends on ppmfd_pkg, ppmfd_alu, ppmfd_store and ppm_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`include "ppm_frame_decoder_assert.svh"

module ppm_frame_decoder #(
  parameter int NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                edge_seen,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ppmfd_pkg::CHANNEL_W-1:0]     channel,
  output logic [ppmfd_pkg::WIDTH_W-1:0]       width_us,
  output logic                                frame_valid,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppmfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FILL_W = $clog2(NUM_CHANNELS + 1);
  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NUM_CHANNELS);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(NUM_CHANNELS - 1);

  ppmfd_pkg::state_t state, state_next;

  logic                                edge_flag;
  logic [ppmfd_pkg::WIDTH_W-1:0]       edge_interval;
  logic [ppmfd_pkg::SILENCE_W-1:0]     silence_count;
  logic [ppmfd_pkg::WIDTH_W-1:0]       cnt;
  logic [FILL_W-1:0]                   fill_index;
  logic                                armed;
  logic [FILL_W-1:0]                   pub_idx;
  logic [ppmfd_pkg::WIDTH_W-1:0]       sync_threshold_us;
  logic [ppmfd_pkg::SILENCE_W-1:0]     failsafe_timeout_us;

  ppmfd_pkg::alu_req_t alu_req;
  ppmfd_pkg::alu_rsp_t alu_rsp;

  logic                          st_wr_en;
  logic [ppmfd_pkg::WIDTH_W-1:0] st_rd_data;
  logic                          in_take;
  logic                          out_free;
  logic                          pub_last;
  logic                          load_frame;
  logic                          load_fail;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pub_last = (pub_idx == FILL_LAST);
  assign cfg_ready = 1'b1;

  ppmfd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ppmfd_store #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (fill_index[ADDR_W-1:0]),
    .wr_data (cnt),
    .rd_addr (pub_idx[ADDR_W-1:0]),
    .rd_data (st_rd_data)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ppmfd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ppmfd_pkg::ST_COUNT;
        end
      end
      ppmfd_pkg::ST_COUNT: begin
        state_next = edge_flag ? ppmfd_pkg::ST_SYNC : ppmfd_pkg::ST_SILENCE;
      end
      ppmfd_pkg::ST_SYNC: begin
        if (alu_rsp.gt && fill_index == FILL_FULL) begin
          state_next = ppmfd_pkg::ST_RD;
        end else begin
          state_next = ppmfd_pkg::ST_IDLE;
        end
      end
      ppmfd_pkg::ST_SILENCE: begin
        state_next = ppmfd_pkg::ST_FAILCHK;
      end
      ppmfd_pkg::ST_FAILCHK: begin
        state_next = alu_rsp.gt ? ppmfd_pkg::ST_FAIL : ppmfd_pkg::ST_IDLE;
      end
      ppmfd_pkg::ST_FAIL: begin
        if (out_free) begin
          state_next = ppmfd_pkg::ST_IDLE;
        end
      end
      ppmfd_pkg::ST_RD: begin
        state_next = ppmfd_pkg::ST_PUB;
      end
      ppmfd_pkg::ST_PUB: begin
        if (out_free) begin
          state_next = pub_last ? ppmfd_pkg::ST_IDLE : ppmfd_pkg::ST_RD;
        end
      end
      default: begin
        state_next = ppmfd_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: shared unit operands, store write and output loads.
  always_comb begin
    in_stall      = 1'b1;
    alu_req.op    = ppmfd_pkg::ALU_INC;
    alu_req.a     = '0;
    alu_req.b     = '0;
    st_wr_en      = 1'b0;
    load_frame    = 1'b0;
    load_fail     = 1'b0;
    case (state)
      ppmfd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      ppmfd_pkg::ST_COUNT: begin
        alu_req.op = ppmfd_pkg::ALU_INC;
        alu_req.a  = ppmfd_pkg::SILENCE_W'(edge_interval);
        alu_req.b  = ppmfd_pkg::SILENCE_W'(ppmfd_pkg::WIDTH_MAX);
      end
      ppmfd_pkg::ST_SYNC: begin
        alu_req.op = ppmfd_pkg::ALU_GT;
        alu_req.a  = ppmfd_pkg::SILENCE_W'(cnt);
        alu_req.b  = ppmfd_pkg::SILENCE_W'(sync_threshold_us);
        st_wr_en   = !alu_rsp.gt && armed && (fill_index < FILL_FULL);
      end
      ppmfd_pkg::ST_SILENCE: begin
        alu_req.op = ppmfd_pkg::ALU_INC;
        alu_req.a  = silence_count;
        alu_req.b  = ppmfd_pkg::SILENCE_MAX;
      end
      ppmfd_pkg::ST_FAILCHK: begin
        alu_req.op = ppmfd_pkg::ALU_GT;
        alu_req.a  = silence_count;
        alu_req.b  = failsafe_timeout_us;
      end
      ppmfd_pkg::ST_FAIL: begin
        load_fail = out_free;
      end
      ppmfd_pkg::ST_RD: begin
        in_stall = 1'b1;
      end
      ppmfd_pkg::ST_PUB: begin
        load_frame = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppmfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_threshold_us   <= ppmfd_pkg::SYNC_RESET;
      failsafe_timeout_us <= ppmfd_pkg::FAILSAFE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ppmfd_pkg::REG_SYNC_THRESHOLD) begin
        sync_threshold_us <= cfg_data[ppmfd_pkg::WIDTH_W-1:0];
      end else if (cfg_index == ppmfd_pkg::REG_FAILSAFE) begin
        failsafe_timeout_us <= cfg_data[ppmfd_pkg::SILENCE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      edge_flag <= edge_seen;
    end
    if (state == ppmfd_pkg::ST_COUNT) begin
      cnt <= alu_rsp.result[ppmfd_pkg::WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_interval <= '0;
      silence_count <= '0;
      fill_index    <= '0;
      armed         <= 1'b0;
      pub_idx       <= '0;
    end else begin
      case (state)
        ppmfd_pkg::ST_SYNC: begin
          edge_interval <= '0;
          silence_count <= '0;
          if (alu_rsp.gt) begin
            fill_index <= '0;
            armed      <= 1'b1;
            pub_idx    <= '0;
          end else if (armed) begin
            if (fill_index < FILL_FULL) begin
              fill_index <= fill_index + 1'b1;
            end else begin
              armed      <= 1'b0;
              fill_index <= '0;
            end
          end
        end
        ppmfd_pkg::ST_SILENCE: begin
          edge_interval <= cnt;
          silence_count <= alu_rsp.result;
        end
        ppmfd_pkg::ST_FAILCHK: begin
          if (alu_rsp.gt) begin
            silence_count <= '0;
          end
        end
        ppmfd_pkg::ST_PUB: begin
          if (out_free) begin
            pub_idx <= pub_idx + 1'b1;
          end
        end
        default: begin
          pub_idx <= pub_idx;
        end
      endcase
    end
  end

  // Output register; the next item may be accepted while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_frame || load_fail) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_frame) begin
      channel     <= pub_idx[ppmfd_pkg::CHANNEL_W-1:0];
      width_us    <= st_rd_data;
      frame_valid <= 1'b1;
      last        <= pub_last;
    end else if (load_fail) begin
      channel     <= '0;
      width_us    <= '0;
      frame_valid <= 1'b0;
      last        <= 1'b1;
    end
  end

  `PPMFD_ASSERT_IMP(a_fill_bound, 1'b1, fill_index <= FILL_FULL)
  `PPMFD_ASSERT_IMP(a_disarmed_empty, !armed, fill_index == '0)
  `PPMFD_ASSERT_NXT(a_take_busy, in_take, state != ppmfd_pkg::ST_IDLE)
  `PPMFD_ASSERT_IMP(a_failsafe_zero, out_valid && !frame_valid,
                    channel == '0 && width_us == '0 && last)

endmodule
